>>> hw/rtl/dcgc_pkg.sv
// Shared types and constants for the double clap gap classifier.
`timescale 1ns / 1ps

package dcgc_pkg;

  // Configuration register widths
  localparam int PULSE_CFG_W = 17;
  localparam int GAP_CFG_W   = 24;
  localparam int HOLD_W      = 21;
  localparam int LAMP_W      = 4;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_FIRST_MIN  = 3'd0;
  localparam logic [2:0] REG_FIRST_MAX  = 3'd1;
  localparam logic [2:0] REG_SECOND_MIN = 3'd2;
  localparam logic [2:0] REG_SECOND_MAX = 3'd3;
  localparam logic [2:0] REG_GAP_START  = 3'd4;
  localparam logic [2:0] REG_GAP_STEP   = 3'd5;
  localparam logic [2:0] REG_HOLD_TICKS = 3'd6;
  localparam logic [2:0] REG_PAIR_TMO   = 3'd7;

  // Reset values
  localparam logic [PULSE_CFG_W-1:0] RST_FIRST_MIN  = 17'd62260;
  localparam logic [PULSE_CFG_W-1:0] RST_FIRST_MAX  = 17'd67040;
  localparam logic [PULSE_CFG_W-1:0] RST_SECOND_MIN = 17'd106760;
  localparam logic [PULSE_CFG_W-1:0] RST_SECOND_MAX = 17'd113840;
  localparam logic [GAP_CFG_W-1:0]   RST_GAP_START  = 24'd2000000;
  localparam logic [GAP_CFG_W-1:0]   RST_GAP_STEP   = 24'd2000000;
  localparam logic [HOLD_W-1:0]      RST_HOLD_TICKS = 21'd1505021;
  localparam logic [GAP_CFG_W-1:0]   RST_PAIR_TMO   = 24'd12058624;

  typedef struct packed {
    logic [PULSE_CFG_W-1:0] first_pulse_min;
    logic [PULSE_CFG_W-1:0] first_pulse_max;
    logic [PULSE_CFG_W-1:0] second_pulse_min;
    logic [PULSE_CFG_W-1:0] second_pulse_max;
    logic [GAP_CFG_W-1:0]   gap_start;
    logic [GAP_CFG_W-1:0]   gap_step;
    logic [HOLD_W-1:0]      hold_ticks;
    logic [GAP_CFG_W-1:0]   pair_timeout;
  } cfg_t;

  typedef struct packed {
    logic [LAMP_W-1:0] channel_lamps;
    logic              clap_lamp;
  } res_t;

endpackage

>>> hw/rtl/dcgc_gap_bins.sv
// Gap classifier: picks the gap bin of a latched gap count.
`timescale 1ns / 1ps

module dcgc_gap_bins #(
  parameter int GAP_COUNT_BITS = 24,
  parameter int CHANNELS       = 4
) (
  input  logic [GAP_COUNT_BITS-1:0]           gap,
  input  logic [dcgc_pkg::GAP_CFG_W-1:0]      gap_start,
  input  logic [dcgc_pkg::GAP_CFG_W-1:0]      gap_step,
  output logic [$clog2(CHANNELS+1)-1:0]       chan
);
  import dcgc_pkg::*;

  localparam int CW = $clog2(CHANNELS + 1);
  localparam int GW = (GAP_COUNT_BITS > GAP_CFG_W) ? GAP_COUNT_BITS : GAP_CFG_W;
  localparam int TW = GW + 4;

  logic [GAP_CFG_W-1:0] step_eff;
  logic [GW-1:0]        g_ext;
  logic [GW-1:0]        s_ext;
  logic [GW-1:0]        diff;
  logic                 below;
  logic [CHANNELS-1:0]  hits;
  logic [CW-1:0]        cnt;

  assign step_eff = (gap_step == '0) ? GAP_CFG_W'(1) : gap_step;
  assign g_ext    = GW'(gap);
  assign s_ext    = GW'(gap_start);
  assign below    = g_ext < s_ext;
  assign diff     = g_ext - s_ext;

  // Thermometer of bin edges: edge k sits at k * step above the start
  for (genvar k = 1; k <= CHANNELS; k++) begin : g_edge
    logic [TW-1:0] thr;
    assign thr         = TW'(step_eff) * TW'(k);
    assign hits[k-1]   = TW'(diff) >= thr;
  end

  always_comb begin
    cnt = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      cnt = cnt + CW'(hits[i]);
    end
  end

  // A count equal to CHANNELS means past the last bin: no channel
  assign chan = below ? CW'(CHANNELS) : cnt;

endmodule

>>> hw/rtl/dcgc_core.sv
// Clap detector state: pulse timing, pair arming, hold timers, result per tick.
`timescale 1ns / 1ps

module dcgc_core #(
  parameter int PULSE_COUNT_BITS = 17,
  parameter int GAP_COUNT_BITS   = 24,
  parameter int CHANNELS         = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              fire,
  input  logic                              level_high,
  input  logic                              level_mid,
  input  dcgc_pkg::cfg_t                    cfg,
  input  logic [$clog2(CHANNELS+1)-1:0]     chan,
  output logic [GAP_COUNT_BITS-1:0]         gap_latched,
  output dcgc_pkg::res_t                    res
);
  import dcgc_pkg::*;

  localparam int CW  = $clog2(CHANNELS + 1);
  localparam int PW  = PULSE_COUNT_BITS;
  localparam int PCW = (PW > PULSE_CFG_W) ? PW : PULSE_CFG_W;
  localparam int GW  = (GAP_COUNT_BITS > GAP_CFG_W) ? GAP_COUNT_BITS : GAP_CFG_W;
  localparam logic [CW-1:0] NO_CHANNEL = CW'(CHANNELS);
  localparam logic [PW-1:0] PULSE_MAX  = {PW{1'b1}};

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_FIRST      = 3'd1;
  localparam logic [2:0] PH_SECOND     = 3'd2;
  localparam logic [2:0] PH_DRAIN_HIGH = 3'd3;
  localparam logic [2:0] PH_DRAIN_MID  = 3'd4;
  localparam logic [2:0] PH_HOLD_CLAP  = 3'd5;
  localparam logic [2:0] PH_HOLD_CHAN  = 3'd6;

  logic [2:0]                phase_r,   phase_nxt;
  logic [PW-1:0]             pulse_r,   pulse_nxt;
  logic [PW-1:0]             first_r,   first_nxt;
  logic                      armed_r,   armed_nxt;
  logic [GAP_COUNT_BITS-1:0] gap_r,     gap_nxt;
  logic [GAP_COUNT_BITS-1:0] latch_r,   latch_nxt;
  logic [HOLD_W-1:0]         hold_r,    hold_nxt;
  logic [CW-1:0]             pend_r,    pend_nxt;

  logic [GAP_COUNT_BITS-1:0] gap_inc;
  logic                      ok1, ok2;

  assign gap_inc = gap_r + GAP_COUNT_BITS'(1);
  assign ok1 = (PCW'(first_r) >= PCW'(cfg.first_pulse_min)) &&
               (PCW'(first_r) <= PCW'(cfg.first_pulse_max));
  assign ok2 = (PCW'(pulse_r) >= PCW'(cfg.second_pulse_min)) &&
               (PCW'(pulse_r) <= PCW'(cfg.second_pulse_max));

  always_comb begin
    phase_nxt = phase_r;
    pulse_nxt = pulse_r;
    first_nxt = first_r;
    armed_nxt = armed_r;
    gap_nxt   = gap_r;
    latch_nxt = latch_r;
    hold_nxt  = hold_r;
    pend_nxt  = pend_r;

    // Gap counter runs while armed and no lamp is lit
    if (armed_r && (phase_r < PH_HOLD_CLAP)) begin
      if (GW'(gap_inc) >= GW'(cfg.pair_timeout)) begin
        armed_nxt = 1'b0;
        gap_nxt   = '0;
      end else begin
        gap_nxt = gap_inc;
      end
    end

    unique case (phase_r)
      PH_IDLE: begin
        if (level_high) begin
          latch_nxt = gap_r;
          pulse_nxt = PW'(1);
          phase_nxt = PH_FIRST;
        end
      end
      PH_FIRST: begin
        if (level_high) begin
          if (pulse_r == PULSE_MAX) begin
            pulse_nxt = '0;
            phase_nxt = PH_DRAIN_HIGH;
          end else begin
            pulse_nxt = pulse_r + PW'(1);
          end
        end else begin
          first_nxt = pulse_r;
          if (level_mid) begin
            pulse_nxt = PW'(1);
            phase_nxt = PH_SECOND;
          end else begin
            pulse_nxt = '0;
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_SECOND: begin
        if (level_mid) begin
          if (pulse_r == PULSE_MAX) begin
            pulse_nxt = '0;
            phase_nxt = PH_DRAIN_MID;
          end else begin
            pulse_nxt = pulse_r + PW'(1);
          end
        end else begin
          pulse_nxt = '0;
          if (ok1 && ok2) begin
            if (armed_nxt) begin
              pend_nxt  = chan;
              armed_nxt = 1'b0;
            end else begin
              pend_nxt  = NO_CHANNEL;
              armed_nxt = 1'b1;
            end
            gap_nxt   = '0;
            hold_nxt  = cfg.hold_ticks;
            phase_nxt = PH_HOLD_CLAP;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_DRAIN_HIGH: begin
        if (!level_high) phase_nxt = PH_IDLE;
      end
      PH_DRAIN_MID: begin
        if (!level_mid) phase_nxt = PH_IDLE;
      end
      PH_HOLD_CLAP: begin
        if (hold_r > HOLD_W'(1)) begin
          hold_nxt = hold_r - HOLD_W'(1);
        end else if (pend_r < NO_CHANNEL) begin
          hold_nxt  = cfg.hold_ticks;
          phase_nxt = PH_HOLD_CHAN;
        end else begin
          hold_nxt  = '0;
          phase_nxt = PH_IDLE;
        end
      end
      PH_HOLD_CHAN: begin
        if (hold_r > HOLD_W'(1)) begin
          hold_nxt = hold_r - HOLD_W'(1);
        end else begin
          hold_nxt  = '0;
          pend_nxt  = NO_CHANNEL;
          phase_nxt = PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // Result reflects the state after this tick
  always_comb begin
    res.clap_lamp = (phase_nxt == PH_HOLD_CLAP);
    for (int i = 0; i < LAMP_W; i++) begin
      res.channel_lamps[i] = (phase_nxt == PH_HOLD_CHAN) && (pend_nxt < NO_CHANNEL) &&
                             (32'(pend_nxt) == i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pulse_r <= '0;
      first_r <= '0;
      armed_r <= 1'b0;
      gap_r   <= '0;
      latch_r <= '0;
      hold_r  <= '0;
      pend_r  <= NO_CHANNEL;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pulse_r <= pulse_nxt;
      first_r <= first_nxt;
      armed_r <= armed_nxt;
      gap_r   <= gap_nxt;
      latch_r <= latch_nxt;
      hold_r  <= hold_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign gap_latched = latch_r;

  a_chan_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HOLD_CHAN) |-> (pend_r < NO_CHANNEL))
    else $error("channel hold without a valid channel");

  a_pulse_only_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (pulse_r != '0) |-> ((phase_r == PH_FIRST) || (phase_r == PH_SECOND)))
    else $error("pulse count live outside pulse timing");

  a_lamps_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> ($onehot0(res.channel_lamps) && !(res.clap_lamp && (res.channel_lamps != '0))))
    else $error("lamp result not exclusive");

  a_hold_freezes_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (phase_r == PH_HOLD_CLAP || phase_r == PH_HOLD_CHAN)) |=> $stable(gap_r))
    else $error("gap counter moved during a hold");

endmodule

>>> hw/rtl/dcgc_out_buf.sv
// Two-entry result buffer: output register plus skid stage.
`timescale 1ns / 1ps

module dcgc_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dcgc_pkg::res_t push_data,
  output logic           push_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output dcgc_pkg::res_t out_data
);
  import dcgc_pkg::*;

  logic out_valid_r;
  logic skid_valid_r;
  res_t out_data_r;
  res_t skid_data_r;

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) out_data_r <= skid_data_r;
    end else if (!out_valid_r || out_ready) begin
      if (push) out_data_r <= push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

>>> hw/rtl/double_clap_gap_classifier.sv
// Top level of the double clap gap classifier: config registers and channel wiring.
//
//  port group | dir | role
//  -----------+-----+-----------------------------------------------------------
//  in_*       | in  | one comparator sample per item (level_high, level_mid)
//  out_*      | out | lamp state after each item (clap_lamp, channel_lamps)
//  cfg_*      | in  | APB register port, eight registers at byte address 4*i
//
// One item per clock while in_tready is high: every item is stepped through the
// detector in the cycle it is accepted and its result lands in the output register
// (or in the skid stage behind a stalled output) at the same edge.
// Throughput is set by the two-entry output buffer: in_tready drops only when
// both the output register and the skid stage hold a result.
// Reset is synchronous, active low; it restores all register defaults and idles
// the detector. A stalled output never loses or repeats a result.
`timescale 1ns / 1ps

module double_clap_gap_classifier #(
  parameter int PULSE_COUNT_BITS = 17,
  parameter int GAP_COUNT_BITS   = 24,
  parameter int CHANNELS         = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [0] level_high, [1] level_mid, [7:2] zero
  // result item stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [0] clap_lamp, [4:1] channel_lamps, [7:5] zero
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import dcgc_pkg::*;

  localparam int CW = $clog2(CHANNELS + 1);

  cfg_t                      cfg_r;
  logic                      cfg_wr;
  logic [2:0]                cfg_idx;
  logic                      fire;
  logic [CW-1:0]             chan;
  logic [GAP_COUNT_BITS-1:0] gap_latched;
  res_t                      res;
  res_t                      out_res;

  // ---------------------------------------------------------------------------
  // Register port: writes land on the access phase, pready tied high
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_pulse_min  <= RST_FIRST_MIN;
      cfg_r.first_pulse_max  <= RST_FIRST_MAX;
      cfg_r.second_pulse_min <= RST_SECOND_MIN;
      cfg_r.second_pulse_max <= RST_SECOND_MAX;
      cfg_r.gap_start        <= RST_GAP_START;
      cfg_r.gap_step         <= RST_GAP_STEP;
      cfg_r.hold_ticks       <= RST_HOLD_TICKS;
      cfg_r.pair_timeout     <= RST_PAIR_TMO;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FIRST_MIN:  cfg_r.first_pulse_min  <= cfg_pwdata[PULSE_CFG_W-1:0];
        REG_FIRST_MAX:  cfg_r.first_pulse_max  <= cfg_pwdata[PULSE_CFG_W-1:0];
        REG_SECOND_MIN: cfg_r.second_pulse_min <= cfg_pwdata[PULSE_CFG_W-1:0];
        REG_SECOND_MAX: cfg_r.second_pulse_max <= cfg_pwdata[PULSE_CFG_W-1:0];
        REG_GAP_START:  cfg_r.gap_start        <= cfg_pwdata[GAP_CFG_W-1:0];
        REG_GAP_STEP:   cfg_r.gap_step         <= cfg_pwdata[GAP_CFG_W-1:0];
        REG_HOLD_TICKS: cfg_r.hold_ticks       <= cfg_pwdata[HOLD_W-1:0];
        REG_PAIR_TMO:   cfg_r.pair_timeout     <= cfg_pwdata[GAP_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back: zero-extend the addressed register
  always_comb begin
    unique case (cfg_idx)
      REG_FIRST_MIN:  cfg_prdata = 32'(cfg_r.first_pulse_min);
      REG_FIRST_MAX:  cfg_prdata = 32'(cfg_r.first_pulse_max);
      REG_SECOND_MIN: cfg_prdata = 32'(cfg_r.second_pulse_min);
      REG_SECOND_MAX: cfg_prdata = 32'(cfg_r.second_pulse_max);
      REG_GAP_START:  cfg_prdata = 32'(cfg_r.gap_start);
      REG_GAP_STEP:   cfg_prdata = 32'(cfg_r.gap_step);
      REG_HOLD_TICKS: cfg_prdata = 32'(cfg_r.hold_ticks);
      REG_PAIR_TMO:   cfg_prdata = 32'(cfg_r.pair_timeout);
      default:        cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath: advance the detector on every accepted item
  // ---------------------------------------------------------------------------
  assign fire = in_tvalid && in_tready;

  // Bin the gap latched at the start of the current attempt
  dcgc_gap_bins #(
    .GAP_COUNT_BITS (GAP_COUNT_BITS),
    .CHANNELS       (CHANNELS)
  ) u_bins (
    .gap       (gap_latched),
    .gap_start (cfg_r.gap_start),
    .gap_step  (cfg_r.gap_step),
    .chan      (chan)
  );

  dcgc_core #(
    .PULSE_COUNT_BITS (PULSE_COUNT_BITS),
    .GAP_COUNT_BITS   (GAP_COUNT_BITS),
    .CHANNELS         (CHANNELS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .level_high  (in_tdata[0]),
    .level_mid   (in_tdata[1]),
    .cfg         (cfg_r),
    .chan        (chan),
    .gap_latched (gap_latched),
    .res         (res)
  );

  // Hold results here so the input side can take one more item while the output stalls
  dcgc_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire),
    .push_data  (res),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {3'b000, out_res.channel_lamps, out_res.clap_lamp};

endmodule
